### src/segment_box_overlap_test_core_assert.svh
// assertion macros for the segment box overlap test core
`ifndef SEGMENT_BOX_OVERLAP_TEST_CORE_ASSERT_SVH
`define SEGMENT_BOX_OVERLAP_TEST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SBOT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbot assertion failed");

`define SBOT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sbot assertion failed");

`else

`define SBOT_ASSERT_IMPL(lbl, ante, cons)

`define SBOT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/sbot_pkg.sv
package sbot_pkg;

    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned NUM_STAGES = 5;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned DIR_W      = 16;
    localparam int unsigned HLEN_W     = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    // doubled half size, doubled offset
    localparam int unsigned S2_W      = COORD_W + 1;
    localparam int unsigned T2_W      = COORD_W + 3;
    localparam int unsigned ABS_T_W   = COORD_W + 2;
    // hl * |dir|, then scaled by 8 into doubled Q16.16
    localparam int unsigned REACH_W   = 31;
    localparam int unsigned REACH_SH  = 3;
    localparam int unsigned BOX_CMP_W = REACH_W + REACH_SH + 2;
    // cross axis terms
    localparam int unsigned RP_W      = S2_W + DIR_W + 1;
    localparam int unsigned DP_W      = T2_W + DIR_W;
    localparam int unsigned R_W       = RP_W + 1;
    localparam int unsigned DIST_W    = DP_W + 1;

    // the two other axes used by each cross axis
    localparam int unsigned AXIS_P [NUM_AXES] = '{1, 2, 0};
    localparam int unsigned AXIS_Q [NUM_AXES] = '{2, 0, 1};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage

### src/sbot_datapath.sv
module sbot_datapath (
    input  logic                                  aclk,
    input  sbot_pkg::pipe_ctrl_t                  ctrl,
    input  logic signed [sbot_pkg::COORD_W-1:0]   box_min [sbot_pkg::NUM_AXES],
    input  logic signed [sbot_pkg::COORD_W-1:0]   box_max [sbot_pkg::NUM_AXES],
    input  logic signed [sbot_pkg::COORD_W-1:0]   mid     [sbot_pkg::NUM_AXES],
    input  logic signed [sbot_pkg::DIR_W-1:0]     dir     [sbot_pkg::NUM_AXES],
    input  logic        [sbot_pkg::HLEN_W-1:0]    half_length,
    output logic                                  hit
);

    localparam int unsigned NA = sbot_pkg::NUM_AXES;

    // stage 1: half sizes, offsets, absolute directions
    logic signed [sbot_pkg::S2_W-1:0]    s2_1_reg [NA], s2_1_next [NA];
    logic signed [sbot_pkg::T2_W-1:0]    t2_1_reg [NA], t2_1_next [NA];
    logic signed [sbot_pkg::DIR_W-1:0]   d_1_reg  [NA];
    logic        [sbot_pkg::DIR_W-1:0]   ad_1_reg [NA], ad_1_next [NA];
    logic        [sbot_pkg::HLEN_W-1:0]  hl_1_reg;

    // stage 2: products
    logic signed [sbot_pkg::S2_W-1:0]    s2_2_reg    [NA];
    logic signed [sbot_pkg::T2_W-1:0]    t2_2_reg    [NA];
    logic        [sbot_pkg::REACH_W-1:0] reach_2_reg [NA], reach_2_next [NA];
    logic signed [sbot_pkg::RP_W-1:0]    rp_2_reg    [NA], rp_2_next [NA];
    logic signed [sbot_pkg::RP_W-1:0]    rq_2_reg    [NA], rq_2_next [NA];
    logic signed [sbot_pkg::DP_W-1:0]    dp_2_reg    [NA], dp_2_next [NA];
    logic signed [sbot_pkg::DP_W-1:0]    dq_2_reg    [NA], dq_2_next [NA];

    // stage 3: sums
    logic signed [sbot_pkg::BOX_CMP_W-1:0] rhs_3_reg   [NA], rhs_3_next   [NA];
    logic        [sbot_pkg::ABS_T_W-1:0]   abs_t_3_reg [NA], abs_t_3_next [NA];
    logic signed [sbot_pkg::R_W-1:0]       r_3_reg     [NA], r_3_next     [NA];
    logic signed [sbot_pkg::DIST_W-1:0]    dist_3_reg  [NA], dist_3_next  [NA];

    // stage 4: box axis compare, cross distance magnitude
    logic        [NA-1:0]                  box_sep_4_reg, box_sep_4_next;
    logic signed [sbot_pkg::R_W-1:0]       r_4_reg      [NA];
    logic signed [sbot_pkg::DIST_W-1:0]    adist_4_reg  [NA], adist_4_next [NA];

    // stage 5: result
    logic                                  hit_reg, hit_next;

    logic signed [sbot_pkg::DIR_W:0]       dir_abs_wide [NA];
    logic signed [sbot_pkg::T2_W-1:0]      t2_abs_wide  [NA];
    logic        [2*sbot_pkg::HLEN_W-1:0]  reach_wide   [NA];
    logic        [NA-1:0]                  cross_sep;

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            s2_1_next[a] = sbot_pkg::S2_W'(box_max[a]) - sbot_pkg::S2_W'(box_min[a]);
            t2_1_next[a] = sbot_pkg::T2_W'(box_max[a]) + sbot_pkg::T2_W'(box_min[a])
                         - (sbot_pkg::T2_W'(mid[a]) <<< 1);
            dir_abs_wide[a] = dir[a][sbot_pkg::DIR_W-1]
                            ? -((sbot_pkg::DIR_W+1)'(dir[a]))
                            : (sbot_pkg::DIR_W+1)'(dir[a]);
            ad_1_next[a] = dir_abs_wide[a][sbot_pkg::DIR_W-1:0];
        end
    end

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            reach_wide[a]   = (2*sbot_pkg::HLEN_W)'(hl_1_reg) *
                              (2*sbot_pkg::HLEN_W)'(ad_1_reg[a]);
            reach_2_next[a] = reach_wide[a][sbot_pkg::REACH_W-1:0];
            rp_2_next[a] = s2_1_reg[sbot_pkg::AXIS_P[a]] *
                           $signed({1'b0, ad_1_reg[sbot_pkg::AXIS_Q[a]]});
            rq_2_next[a] = s2_1_reg[sbot_pkg::AXIS_Q[a]] *
                           $signed({1'b0, ad_1_reg[sbot_pkg::AXIS_P[a]]});
            dp_2_next[a] = t2_1_reg[sbot_pkg::AXIS_P[a]] * d_1_reg[sbot_pkg::AXIS_Q[a]];
            dq_2_next[a] = t2_1_reg[sbot_pkg::AXIS_Q[a]] * d_1_reg[sbot_pkg::AXIS_P[a]];
        end
    end

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            rhs_3_next[a] = sbot_pkg::BOX_CMP_W'(s2_2_reg[a]) +
                            $signed({2'b00, reach_2_reg[a], sbot_pkg::REACH_SH'(0)});
            t2_abs_wide[a]  = t2_2_reg[a][sbot_pkg::T2_W-1] ? -t2_2_reg[a] : t2_2_reg[a];
            abs_t_3_next[a] = t2_abs_wide[a][sbot_pkg::ABS_T_W-1:0];
            r_3_next[a]     = sbot_pkg::R_W'(rp_2_reg[a]) + sbot_pkg::R_W'(rq_2_reg[a]);
            dist_3_next[a]  = sbot_pkg::DIST_W'(dp_2_reg[a]) - sbot_pkg::DIST_W'(dq_2_reg[a]);
        end
    end

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            box_sep_4_next[a] = $signed({2'b00, abs_t_3_reg[a]}) > rhs_3_reg[a];
            adist_4_next[a]   = dist_3_reg[a][sbot_pkg::DIST_W-1] ? -dist_3_reg[a]
                                                                  : dist_3_reg[a];
        end
    end

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            cross_sep[a] = adist_4_reg[a] > sbot_pkg::DIST_W'(r_4_reg[a]);
        end
        hit_next = ~(|box_sep_4_reg) & ~(|cross_sep);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            s2_1_reg <= s2_1_next;
            t2_1_reg <= t2_1_next;
            d_1_reg  <= dir;
            ad_1_reg <= ad_1_next;
            hl_1_reg <= half_length;
        end
        if (ctrl.load[1]) begin
            s2_2_reg    <= s2_1_reg;
            t2_2_reg    <= t2_1_reg;
            reach_2_reg <= reach_2_next;
            rp_2_reg    <= rp_2_next;
            rq_2_reg    <= rq_2_next;
            dp_2_reg    <= dp_2_next;
            dq_2_reg    <= dq_2_next;
        end
        if (ctrl.load[2]) begin
            rhs_3_reg   <= rhs_3_next;
            abs_t_3_reg <= abs_t_3_next;
            r_3_reg     <= r_3_next;
            dist_3_reg  <= dist_3_next;
        end
        if (ctrl.load[3]) begin
            box_sep_4_reg <= box_sep_4_next;
            r_4_reg       <= r_3_reg;
            adist_4_reg   <= adist_4_next;
        end
        if (ctrl.load[4]) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

### src/segment_box_overlap_test_core.sv
// Segment versus axis-aligned box overlap test. The box corners are written
// through the cfg port (index 0..2 lower corner x/y/z, 3..5 upper corner x/y/z,
// signed Q16.16, reset 0; other indexes are ignored); the user must write them
// only while no item is in flight, which the block does not enforce. Each input
// item is a segment (midpoint Q16.16, direction Q2.14, integer half length);
// the result item is hit, high when none of the six separating axes separates
// the segment from the box, touching counts as hit. The datapath is a five-stage
// pipeline (offsets, products, sums, compare, final compare) that takes one
// item every clock unless m_ready stalls it; a stage holds only while the next
// stage is full and stalled, so bubbles close up under m_ready back pressure.
`include "segment_box_overlap_test_core_assert.svh"

module segment_box_overlap_test_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sbot_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sbot_pkg::COORD_W-1:0]          cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sbot_pkg::COORD_W-1:0]   s_mid_x,
    input  logic signed [sbot_pkg::COORD_W-1:0]   s_mid_y,
    input  logic signed [sbot_pkg::COORD_W-1:0]   s_mid_z,
    input  logic signed [sbot_pkg::DIR_W-1:0]     s_dir_x,
    input  logic signed [sbot_pkg::DIR_W-1:0]     s_dir_y,
    input  logic signed [sbot_pkg::DIR_W-1:0]     s_dir_z,
    input  logic        [sbot_pkg::HLEN_W-1:0]    s_half_length,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit
);

    localparam int unsigned NS = sbot_pkg::NUM_STAGES;
    localparam int unsigned NA = sbot_pkg::NUM_AXES;

    logic signed [sbot_pkg::COORD_W-1:0] box_min_reg [NA], box_min_next [NA];
    logic signed [sbot_pkg::COORD_W-1:0] box_max_reg [NA], box_max_next [NA];
    logic signed [sbot_pkg::COORD_W-1:0] mid [NA];
    logic signed [sbot_pkg::DIR_W-1:0]   dir [NA];

    logic [NS-1:0]        valid_reg, valid_next;
    logic [NS-1:0]        stage_ready;
    sbot_pkg::pipe_ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    // config register write
    always_comb begin
        box_min_next = box_min_reg;
        box_max_next = box_max_reg;
        if (cfg_valid) begin
            unique case (sbot_pkg::cfg_index_t'(cfg_index))
                sbot_pkg::CFG_BOX_MIN_X: box_min_next[0] = $signed(cfg_data);
                sbot_pkg::CFG_BOX_MIN_Y: box_min_next[1] = $signed(cfg_data);
                sbot_pkg::CFG_BOX_MIN_Z: box_min_next[2] = $signed(cfg_data);
                sbot_pkg::CFG_BOX_MAX_X: box_max_next[0] = $signed(cfg_data);
                sbot_pkg::CFG_BOX_MAX_Y: box_max_next[1] = $signed(cfg_data);
                sbot_pkg::CFG_BOX_MAX_Z: box_max_next[2] = $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NA; a++) begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end else begin
            box_min_reg <= box_min_next;
            box_max_reg <= box_max_next;
        end
    end

    // per-stage flow control
    always_comb begin
        stage_ready[NS-1] = ~valid_reg[NS-1] | m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_ready[k] = ~valid_reg[k] | stage_ready[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            if (stage_ready[k]) begin
                valid_next[k] = (k == 0) ? s_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
        ctrl.load = stage_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[NS-1];

    assign mid = '{s_mid_x, s_mid_y, s_mid_z};
    assign dir = '{s_dir_x, s_dir_y, s_dir_z};

    sbot_datapath u_datapath (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .box_min     (box_min_reg),
        .box_max     (box_max_reg),
        .mid         (mid),
        .dir         (dir),
        .half_length (s_half_length),
        .hit         (m_hit)
    );

    `SBOT_ASSERT_IMPL(a_empty_pipe_ready, valid_reg == '0, s_ready)
    `SBOT_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, valid_reg[0])
    `SBOT_ASSERT_NEXT(a_bubble_closes, valid_reg[NS-2] && !valid_reg[NS-1], valid_reg[NS-1])
    `SBOT_ASSERT_NEXT(a_cfg_min_x_write, cfg_valid && cfg_index == sbot_pkg::CFG_BOX_MIN_X, box_min_reg[0] == $signed($past(cfg_data)))

endmodule

### tb/segment_box_overlap_test_core_tb.sv
module segment_box_overlap_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbot_pkg::*;

    localparam longint UNIT          = 64'sd65536;
    localparam longint MIN_SPAN      = 4 * UNIT;
    localparam longint MID_LOWEST    = -64'sd2147483648;
    localparam longint MID_HIGHEST   = 64'sd2147483647;
    localparam longint CENTER_SCALE  = 2;
    localparam int     DIR_ALIGN     = 2;
    localparam longint REACH_SCALE   = CENTER_SCALE << DIR_ALIGN;
    localparam int     ONE_DIR       = 16384;
    localparam int     DIR_LOWEST    = -32768;
    localparam int     DIR_HIGHEST   = 32767;
    localparam int     BOX_REACH     = 64 * 65536;
    localparam int     BOX_SPAN      = 32 * 65536;
    localparam int     MAX_GAP       = 10;
    localparam int     HOLD_CYCLES   = 60;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     RESET_CYCLES  = 5;
    localparam int     PHASE_ITEMS   = 200;
    localparam int     HOLD_PHASE    = 4;
    localparam int     MAX_REPORTS   = 10;
    localparam int unsigned CYCLE_LIMIT = 500000;

    localparam logic [COORD_W-1:0]   COORD_MIN    = 32'h8000_0000;
    localparam logic [COORD_W-1:0]   COORD_MAX    = 32'h7fff_ffff;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] mid;
        logic [NUM_AXES-1:0][DIR_W-1:0]   dir;
        logic [HLEN_W-1:0]                half_len;
    } segment_t;

    typedef enum int {
        BOX_RANDOM,
        BOX_TINY,
        BOX_FLAT,
        BOX_INVERTED,
        BOX_FULL_RANGE,
        BOX_FULL_INVERTED
    } box_kind_t;

    class overlap_scoreboard;
        longint box_lo [NUM_AXES];
        longint box_hi [NUM_AXES];
        bit     hit_q [$];
        int     failures;
        int     checked;
        int     hits;

        function new();
            foreach (box_lo[a]) begin
                box_lo[a] = 0;
                box_hi[a] = 0;
            end
            failures = 0;
            checked  = 0;
            hits     = 0;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function int pending();
            return hit_q.size();
        endfunction

        function void write_box(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
            longint v;
            v = longint'($signed(data));
            case (idx)
                CFG_BOX_MIN_X: box_lo[0] = v;
                CFG_BOX_MIN_Y: box_lo[1] = v;
                CFG_BOX_MIN_Z: box_lo[2] = v;
                CFG_BOX_MAX_X: box_hi[0] = v;
                CFG_BOX_MAX_Y: box_hi[1] = v;
                CFG_BOX_MAX_Z: box_hi[2] = v;
                default: ;
            endcase
        endfunction

        // every comparison doubled so the half size and center stay exact
        function bit predict_hit(segment_t seg);
            longint s2 [NUM_AXES];
            longint t2 [NUM_AXES];
            longint d  [NUM_AXES];
            longint ad [NUM_AXES];
            longint hl, reach, r, sep_dist;
            int     p, q;
            bit     hit;
            hit = 1'b1;
            hl  = longint'(seg.half_len);
            for (int a = 0; a < NUM_AXES; a++) begin
                s2[a] = box_hi[a] - box_lo[a];
                t2[a] = box_hi[a] + box_lo[a] - CENTER_SCALE * longint'($signed(seg.mid[a]));
                d[a]  = longint'($signed(seg.dir[a]));
                ad[a] = mag(d[a]);
            end
            for (int a = 0; a < NUM_AXES; a++) begin
                reach = hl * ad[a] * REACH_SCALE;
                if (mag(t2[a]) > s2[a] + reach)
                    hit = 1'b0;
            end
            for (int a = 0; a < NUM_AXES; a++) begin
                p        = (a + 1) % NUM_AXES;
                q        = (a + 2) % NUM_AXES;
                r        = s2[p] * ad[q] + s2[q] * ad[p];
                sep_dist = t2[p] * d[q] - t2[q] * d[p];
                if (mag(sep_dist) > r)
                    hit = 1'b0;
            end
            return hit;
        endfunction

        function void note_segment(segment_t seg);
            hit_q.push_back(predict_hit(seg));
        endfunction

        function void check_hit(logic got);
            bit want;
            if (hit_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result %0d: hit=%b with no segment outstanding", checked, got);
            end else begin
                want = hit_q.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("result %0d: expected hit=%b, got hit=%b", checked, want, got);
                end
                hits += int'(want);
            end
            checked++;
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [COORD_W-1:0]          cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [COORD_W-1:0]   s_mid_x;
    logic signed [COORD_W-1:0]   s_mid_y;
    logic signed [COORD_W-1:0]   s_mid_z;
    logic signed [DIR_W-1:0]     s_dir_x;
    logic signed [DIR_W-1:0]     s_dir_y;
    logic signed [DIR_W-1:0]     s_dir_z;
    logic        [HLEN_W-1:0]    s_half_length;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_hit;

    overlap_scoreboard sb = new();

    bit          tx_no_idle   = 1'b0;
    bit          rx_no_idle   = 1'b0;
    bit          hold_request = 1'b0;
    int          hold_count   = 0;
    int          boxes        = 0;
    int unsigned cycles       = 0;

    box_kind_t phase_plan [9] = '{BOX_RANDOM, BOX_FULL_RANGE, BOX_TINY, BOX_INVERTED,
                                  BOX_RANDOM, BOX_FLAT, BOX_FULL_INVERTED, BOX_RANDOM,
                                  BOX_TINY};

    segment_box_overlap_test_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mid_x       (s_mid_x),
        .s_mid_y       (s_mid_y),
        .s_mid_z       (s_mid_z),
        .s_dir_x       (s_dir_x),
        .s_dir_y       (s_dir_y),
        .s_dir_z       (s_dir_z),
        .s_half_length (s_half_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic segment_t make_seg(longint mx, longint my, longint mz,
                                          int dx, int dy, int dz, int hl);
        segment_t seg;
        seg.mid[0]   = 32'(mx);
        seg.mid[1]   = 32'(my);
        seg.mid[2]   = 32'(mz);
        seg.dir[0]   = 16'(dx);
        seg.dir[1]   = 16'(dy);
        seg.dir[2]   = 16'(dz);
        seg.half_len = 16'(hl);
        return seg;
    endfunction

    // segments scattered around the current box so both outcomes show up
    function automatic segment_t near_segment();
        segment_t  seg;
        longint    center, span, off;
        bit [62:0] roll;
        int        pick, axis;
        for (int a = 0; a < NUM_AXES; a++) begin
            center = (sb.box_lo[a] + sb.box_hi[a]) / 2;
            span   = sb.mag(sb.box_hi[a] - sb.box_lo[a]) / 2 + MIN_SPAN;
            roll   = 63'({$urandom, $urandom});
            off    = longint'(roll) % (4 * span + 1) - 2 * span;
            seg.mid[a] = 32'(center + off);
        end
        pick = $urandom_range(0, 9);
        axis = $urandom_range(0, 2);
        for (int a = 0; a < NUM_AXES; a++) begin
            if (pick == 0)
                seg.dir[a] = '0;
            else if (pick <= 2)
                seg.dir[a] = (a == axis) ? 16'(int'($urandom_range(0, 2 * ONE_DIR)) - ONE_DIR)
                                         : '0;
            else if (pick <= 7)
                seg.dir[a] = 16'(int'($urandom_range(0, 2 * ONE_DIR)) - ONE_DIR);
            else
                seg.dir[a] = 16'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            seg.half_len = '0;
        else if (pick <= 7)
            seg.half_len = 16'($urandom_range(0, 48));
        else
            seg.half_len = 16'($urandom);
        return seg;
    endfunction

    function automatic segment_t noise_segment();
        segment_t seg;
        for (int a = 0; a < NUM_AXES; a++) begin
            seg.mid[a] = $urandom;
            seg.dir[a] = 16'($urandom);
        end
        seg.half_len = 16'($urandom);
        return seg;
    endfunction

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_box(idx, value);
    endtask

    // spare indexes get junk that must not disturb the box
    task automatic write_box_regs(input logic [NUM_AXES-1:0][COORD_W-1:0] lo,
                                  input logic [NUM_AXES-1:0][COORD_W-1:0] hi);
        write_cfg(CFG_SPARE_LO, $urandom);
        write_cfg(CFG_BOX_MIN_X, lo[0]);
        write_cfg(CFG_BOX_MAX_Z, hi[2]);
        write_cfg(CFG_BOX_MIN_Y, lo[1]);
        write_cfg(CFG_BOX_MAX_X, hi[0]);
        write_cfg(CFG_BOX_MIN_Z, lo[2]);
        write_cfg(CFG_BOX_MAX_Y, hi[1]);
        write_cfg(CFG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        boxes++;
    endtask

    task automatic load_box(input box_kind_t kind);
        logic [NUM_AXES-1:0][COORD_W-1:0] lo, hi;
        longint base, span;
        int     flat_axis;
        flat_axis = $urandom_range(0, 2);
        for (int a = 0; a < NUM_AXES; a++) begin
            base = longint'(int'($urandom_range(0, 2 * BOX_REACH)) - BOX_REACH);
            case (kind)
                BOX_TINY: span = $urandom_range(0, 65536);
                BOX_FLAT: span = (a == flat_axis) ? 0 : $urandom_range(0, BOX_SPAN);
                default:  span = $urandom_range(0, BOX_SPAN);
            endcase
            lo[a] = 32'(base);
            hi[a] = (kind == BOX_INVERTED) ? 32'(base - span) : 32'(base + span);
            if (kind == BOX_FULL_RANGE) begin
                lo[a] = COORD_MIN;
                hi[a] = COORD_MAX;
            end else if (kind == BOX_FULL_INVERTED) begin
                lo[a] = COORD_MAX;
                hi[a] = COORD_MIN;
            end
        end
        write_box_regs(lo, hi);
    endtask

    task automatic send_segment(input segment_t seg);
        int gap;
        gap = (tx_no_idle || hold_request) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mid_x       <= seg.mid[0];
        s_mid_y       <= seg.mid[1];
        s_mid_z       <= seg.mid[2];
        s_dir_x       <= seg.dir[0];
        s_dir_y       <= seg.dir[1];
        s_dir_z       <= seg.dir[2];
        s_half_length <= seg.half_len;
        do @(posedge aclk); while (!s_ready);
        sb.note_segment(seg);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side
    initial begin : result_side
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                hold_count++;
            end
            gap = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_hit(m_hit);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [NUM_AXES-1:0][COORD_W-1:0] lo, hi;
        segment_t seg;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_mid_x       <= '0;
        s_mid_y       <= '0;
        s_mid_z       <= '0;
        s_dir_x       <= '0;
        s_dir_y       <= '0;
        s_dir_z       <= '0;
        s_half_length <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero box out of reset
        for (int i = 0; i < 20; i++)
            send_segment(near_segment());
        drain();

        lo[0] = 32'(-10 * UNIT);
        lo[1] = 32'(-4 * UNIT);
        lo[2] = 32'(-2 * UNIT);
        hi[0] = 32'(10 * UNIT);
        hi[1] = 32'(4 * UNIT);
        hi[2] = 32'(2 * UNIT);
        write_box_regs(lo, hi);

        // points, touching faces and ends, box and cross axes, field extremes
        send_segment(make_seg(0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(11 * UNIT, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(10 * UNIT, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(10 * UNIT + 1, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(0, -4 * UNIT, 2 * UNIT, 0, 0, 0, 0));
        send_segment(make_seg(0, 0, 0, ONE_DIR, 0, 0, 5));
        send_segment(make_seg(20 * UNIT, 0, 0, ONE_DIR, 0, 0, 10));
        send_segment(make_seg(20 * UNIT, 0, 0, ONE_DIR, 0, 0, 9));
        send_segment(make_seg(20 * UNIT, 0, 0, -ONE_DIR, 0, 0, 15));
        send_segment(make_seg(0, 10 * UNIT, 0, 0, ONE_DIR, 0, 6));
        send_segment(make_seg(0, 10 * UNIT, 0, 0, ONE_DIR, 0, 5));
        send_segment(make_seg(12 * UNIT, 6 * UNIT, 0, ONE_DIR, ONE_DIR, 0, 3));
        send_segment(make_seg(12 * UNIT, -6 * UNIT, 0, ONE_DIR, ONE_DIR, 0, 3));
        send_segment(make_seg(0, 0, 5 * UNIT, 0, 0, 0, 65535));
        send_segment(make_seg(5 * UNIT, 0, 3 * UNIT, 0, 0, -ONE_DIR, 1));
        send_segment(make_seg(MID_LOWEST, MID_LOWEST, MID_LOWEST,
                              DIR_LOWEST, DIR_LOWEST, DIR_LOWEST, 65535));
        send_segment(make_seg(MID_HIGHEST, MID_HIGHEST, MID_HIGHEST,
                              DIR_HIGHEST, DIR_HIGHEST, DIR_HIGHEST, 65535));
        send_segment(make_seg(MID_LOWEST, 0, 0, DIR_HIGHEST, 0, 0, 0));
        send_segment(make_seg(0, 0, 0, DIR_LOWEST, DIR_LOWEST, DIR_LOWEST, 1));
        send_segment(make_seg(3 * UNIT, 2 * UNIT, UNIT, DIR_HIGHEST, DIR_LOWEST, 1, 40));
        drain();

        for (int p = 0; p < 9; p++) begin
            tx_no_idle = (p % 3 == 2) || (p == 5);
            rx_no_idle = (p % 3 == 2) || (p == 7);
            load_box(phase_plan[p]);
            // both corners of the box as points
            seg = '0;
            for (int a = 0; a < NUM_AXES; a++)
                seg.mid[a] = 32'(sb.box_lo[a]);
            send_segment(seg);
            for (int a = 0; a < NUM_AXES; a++)
                seg.mid[a] = 32'(sb.box_hi[a]);
            send_segment(seg);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == HOLD_PHASE && i == PHASE_ITEMS / 4)
                    hold_request = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    send_segment(noise_segment());
                else
                    send_segment(near_segment());
            end
            drain();
        end

        $display("%0d segments checked over %0d box settings: %0d hits, %0d misses, %0d failures",
                 sb.checked, boxes, sb.hits, sb.checked - sb.hits, sb.failures);
        $display("boxes ranged from zero and flat to inverted and full range; %0d long result stalls",
                 hold_count);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
